/* src/ulecho_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulecho_pkg
// Shared types, sizes and constants of the line echo buffer.
// ----------------------------------------------------------------------------
package ulecho_pkg;

  // Line store size and header length
  localparam int DEPTH      = 128;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int HEADER_LEN = 11;
  localparam int HDR_POS_W  = 4;

  // Job queue between front and back, power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_END_CHAR     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TRAILER_CHAR = 1'b1;

  localparam logic [7:0] END_CHAR_RST     = 8'd13;
  localparam logic [7:0] TRAILER_CHAR_RST = 8'd10;
  localparam logic [7:0] SPACE_CHAR       = 8'h20;

  // Request kinds on the input channel
  localparam logic ACT_RX_BYTE  = 1'b0;
  localparam logic ACT_TX_READY = 1'b1;

  typedef enum logic [1:0] {
    PH_RECEIVE = 2'd0,
    PH_HEADER  = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    JOB_WRITE   = 2'd0,
    JOB_HEADER  = 2'd1,
    JOB_BODY    = 2'd2,
    JOB_TRAILER = 2'd3
  } job_kind_t;

  // One unit of work for the back end
  typedef struct packed {
    job_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } job_t;

  // Header text "You wrote: ", spaces beyond its end
  function automatic logic [7:0] header_char(input logic [HDR_POS_W-1:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h59;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h75;
      4'd3:    c = 8'h20;
      4'd4:    c = 8'h77;
      4'd5:    c = 8'h72;
      4'd6:    c = 8'h6F;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h65;
      4'd9:    c = 8'h3A;
      4'd10:   c = 8'h20;
      default: c = SPACE_CHAR;
    endcase
    return c;
  endfunction

endpackage

/* src/ulecho_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulecho_front
// Accepts requests, tracks the line phase and indices, and issues jobs.
// ----------------------------------------------------------------------------
module ulecho_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic                              in_tuser,
  input  logic                              cfg_wr_en,
  input  logic [ulecho_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [7:0]                        cfg_wdata,
  output logic                              push,
  output ulecho_pkg::job_t                  push_job
);
  import ulecho_pkg::*;

  localparam logic [HDR_POS_W:0] HDR_LEN_V = (HDR_POS_W + 1)'(HEADER_LEN);
  localparam logic [ADDR_W-1:0]  LAST_IDX  = ADDR_W'(DEPTH - 1);

  phase_t                 phase_r, phase_nxt;
  logic [ADDR_W-1:0]      wr_idx_r, wr_idx_nxt, wr_idx_inc;
  logic [ADDR_W-1:0]      rd_idx_r, rd_idx_nxt, rd_idx_inc;
  logic [HDR_POS_W-1:0]   hdr_pos_r, hdr_pos_nxt, hdr_pos_inc;
  logic [7:0]             end_char_r, trailer_char_r;
  logic                   accept;

  assign accept      = in_tvalid && in_tready;
  assign wr_idx_inc  = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_idx_inc  = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;
  assign hdr_pos_inc = hdr_pos_r + 1'b1;

  // Classify the request and build the job
  always_comb begin
    phase_nxt   = phase_r;
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    hdr_pos_nxt = hdr_pos_r;
    push        = 1'b0;
    push_job    = '{kind: JOB_WRITE, addr: wr_idx_r, data: in_tdata};
    if (accept) begin
      if (in_tuser == ACT_RX_BYTE) begin
        if (phase_r == PH_RECEIVE) begin
          push       = 1'b1;
          wr_idx_nxt = wr_idx_inc;
          if (in_tdata == end_char_r) begin
            hdr_pos_nxt = '0;
            phase_nxt   = (HEADER_LEN == 0) ? PH_BODY : PH_HEADER;
          end
        end
      end else begin
        unique case (phase_r)
          PH_HEADER: begin
            push        = 1'b1;
            push_job    = '{kind: JOB_HEADER, addr: '0, data: header_char(hdr_pos_r)};
            hdr_pos_nxt = hdr_pos_inc;
            if ({1'b0, hdr_pos_inc} >= HDR_LEN_V) begin
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            push       = 1'b1;
            push_job   = '{kind: JOB_BODY, addr: rd_idx_r, data: '0};
            rd_idx_nxt = rd_idx_inc;
            if (rd_idx_inc == wr_idx_r) begin
              phase_nxt = PH_TRAILER;
            end
          end
          PH_TRAILER: begin
            push      = 1'b1;
            push_job  = '{kind: JOB_TRAILER, addr: '0, data: trailer_char_r};
            phase_nxt = PH_RECEIVE;
          end
          PH_RECEIVE: begin
            push = 1'b0;
          end
        endcase
      end
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_RECEIVE;
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      hdr_pos_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      hdr_pos_r <= hdr_pos_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_char_r     <= END_CHAR_RST;
      trailer_char_r <= TRAILER_CHAR_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_END_CHAR) begin
        end_char_r <= cfg_wdata;
      end
      if (cfg_addr == REG_TRAILER_CHAR) begin
        trailer_char_r <= cfg_wdata;
      end
    end
  end

endmodule

/* src/ulecho_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulecho_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module ulecho_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ulecho_pkg::job_t push_job,
  output logic             can_push,
  output logic             head_valid,
  output ulecho_pkg::job_t head_job,
  input  logic             pop
);
  import ulecho_pkg::*;

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign can_push   = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = slot_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* src/ulecho_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulecho_back
// Owns the line store, executes jobs and drives the output register.
// ----------------------------------------------------------------------------
module ulecho_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  ulecho_pkg::job_t head_job,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast
);
  import ulecho_pkg::*;

  logic [7:0] line_store [DEPTH];

  logic       sa_valid_r;
  job_kind_t  sa_kind_r;
  logic [7:0] sa_data_r;
  logic [7:0] rdata_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_last_r;

  logic out_free, sa_adv, sa_ready, load, is_write;

  assign out_free = !out_valid_r || out_tready;
  assign sa_adv   = sa_valid_r && out_free;
  assign sa_ready = !sa_valid_r || out_free;
  assign is_write = (head_job.kind == JOB_WRITE);
  // Writes never need an output slot
  assign pop      = head_valid && (is_write || sa_ready);
  assign load     = pop && !is_write;

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (pop && is_write) begin
      line_store[head_job.addr] <= head_job.data;
    end
    if (load && head_job.kind == JOB_BODY) begin
      rdata_r <= line_store[head_job.addr];
    end
  end

  // Read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_valid_r <= 1'b0;
    end else if (load) begin
      sa_valid_r <= 1'b1;
    end else if (sa_adv) begin
      sa_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sa_kind_r <= head_job.kind;
      sa_data_r <= head_job.data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sa_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sa_adv) begin
      out_data_r <= (sa_kind_r == JOB_BODY) ? rdata_r : sa_data_r;
      out_last_r <= (sa_kind_r == JOB_TRAILER);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/uart_line_echo_buffer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_line_echo_buffer_core
// Serial line echo engine with a circular line store.
// ----------------------------------------------------------------------------
// Takes one request per clock while the job queue has room. Received bytes
// (tuser low) are stored in a 128-byte circular store until the end
// character arrives; then each transmitter-ready request (tuser high) yields
// one output byte: the header "You wrote: ", the stored line, and the
// trailer character with tlast set. Requests that do not fit the current
// phase are dropped without output. A request's result passes through the
// four-entry job queue, the registered store read and the output register.
// in_tready falls only when the job queue is full because the output side
// is stalled. The store has no reset; the indices do.
// ----------------------------------------------------------------------------
module uart_line_echo_buffer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] rx_byte
  input  logic                             in_tuser,   // [0] action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // [7:0] tx_byte
  output logic                             out_tlast,  // line_done
  input  logic                             cfg_wr_en,
  input  logic [ulecho_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [7:0]                       cfg_wdata
);
  import ulecho_pkg::*;

  logic push, can_push, head_valid, pop;
  job_t push_job, head_job;

  assign in_tready = can_push;

  ulecho_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .push_job  (push_job)
  );

  ulecho_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .can_push   (can_push),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  ulecho_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* src/ulecho_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ulecho_checker
// Port-level checks on the line echo buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ulecho_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // Nothing is pending just after reset
  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // The job queue is empty after reset, so requests are taken at once
  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready right after reset");

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid)
    else $error("output withdrawn while stalled");

  // A stalled result keeps its byte and flag
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

endmodule

bind uart_line_echo_buffer_core ulecho_checker u_ulecho_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
